>>> design/lrukv_pkg.sv
// ----------------------------------------------------------------------------
// lrukv_pkg
// Shared constants, codes and types of the LRU key-value cache.
// ----------------------------------------------------------------------------
package lrukv_pkg;

  // Number of entries held by the store.
  localparam int unsigned DEPTH  = 16;
  // Width of an entry index and of a recency rank.
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Width of the occupancy count, which must be able to hold DEPTH itself.
  localparam int unsigned OCC_W  = $clog2(DEPTH + 1);
  // Width of the capacity register as seen on the configuration port.
  localparam int unsigned CAP_W  = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

  // Payload widths.
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned DATA_W = 32;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_e;

  // Outcome of the lookup for one item, handed from the lookup logic to the
  // state update in the top level.
  typedef struct packed {
    logic             hit;     // key found among valid entries
    logic             put;     // item is a put
    logic             alloc;   // put of a new key into a free slot
    logic             evict;   // put of a new key that replaces the LRU entry
    logic [IDX_W-1:0] slot;    // entry that becomes most recent
    logic [OCC_W-1:0] thresh;  // valid entries ranked below this age by one
  } decision_t;

endpackage

>>> design/lrukv_if.sv
// ----------------------------------------------------------------------------
// lrukv_in_if / lrukv_out_if
// Valid/ready channels carrying cache commands and cache results.
// ----------------------------------------------------------------------------
interface lrukv_in_if;
  logic                                  valid;
  logic                                  ready;
  lrukv_pkg::cmd_e                       command;
  logic signed [lrukv_pkg::KEY_W-1:0]    key;
  logic signed [lrukv_pkg::DATA_W-1:0]   value;

  modport source (output valid, output command, output key, output value, input ready);
  modport sink   (input valid, input command, input key, input value, output ready);
endinterface

interface lrukv_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  hit;
  logic signed [lrukv_pkg::DATA_W-1:0]   read_value;
  logic                                  evicted;
  logic signed [lrukv_pkg::KEY_W-1:0]    evicted_key;

  modport source (output valid, output hit, output read_value, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  input evicted_key, output ready);
endinterface

>>> design/lrukv_lookup.sv
// ----------------------------------------------------------------------------
// lrukv_lookup
// Parallel key compare, free-slot search and victim select for one item.
// ----------------------------------------------------------------------------
module lrukv_lookup (
  input  lrukv_pkg::cmd_e                                      command_i,
  input  logic [lrukv_pkg::KEY_W-1:0]                          key_i,
  input  logic [lrukv_pkg::DEPTH-1:0]                          valid_i,
  input  logic [lrukv_pkg::DEPTH-1:0][lrukv_pkg::KEY_W-1:0]    keys_i,
  input  logic [lrukv_pkg::DEPTH-1:0][lrukv_pkg::IDX_W-1:0]    ranks_i,
  input  logic [lrukv_pkg::OCC_W-1:0]                          occupancy_i,
  input  logic [lrukv_pkg::OCC_W-1:0]                          eff_cap_i,
  output lrukv_pkg::decision_t                                 dec_o
);

  logic [lrukv_pkg::DEPTH-1:0] match;
  logic [lrukv_pkg::DEPTH-1:0] victim;
  logic [lrukv_pkg::IDX_W-1:0] match_idx;
  logic [lrukv_pkg::IDX_W-1:0] free_idx;
  logic [lrukv_pkg::IDX_W-1:0] victim_idx;
  logic [lrukv_pkg::IDX_W-1:0] lru_rank;
  logic [lrukv_pkg::IDX_W-1:0] hit_rank;
  logic                        room;

  // The least recent valid entry always holds rank occupancy-1.
  assign lru_rank = lrukv_pkg::IDX_W'(occupancy_i - lrukv_pkg::OCC_W'(1));
  assign room     = (occupancy_i < eff_cap_i);

  always_comb begin
    for (int i = 0; i < lrukv_pkg::DEPTH; i++) begin
      match[i]  = valid_i[i] && (keys_i[i] == key_i);
      victim[i] = valid_i[i] && (ranks_i[i] == lru_rank);
    end
  end

  // Lowest-index encoders; scanning downward leaves the lowest hit last.
  always_comb begin
    match_idx  = '0;
    free_idx   = '0;
    victim_idx = '0;
    hit_rank   = '0;
    for (int i = lrukv_pkg::DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        match_idx = lrukv_pkg::IDX_W'(i);
        hit_rank  = ranks_i[i];
      end
      if (!valid_i[i]) begin
        free_idx = lrukv_pkg::IDX_W'(i);
      end
      if (victim[i]) begin
        victim_idx = lrukv_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    dec_o        = '0;
    dec_o.hit    = |match;
    dec_o.put    = (command_i == lrukv_pkg::CMD_PUT);
    if (dec_o.hit) begin
      dec_o.slot   = match_idx;
      dec_o.thresh = lrukv_pkg::OCC_W'(hit_rank);
    end else if (dec_o.put && room) begin
      dec_o.alloc  = 1'b1;
      dec_o.slot   = free_idx;
      dec_o.thresh = lrukv_pkg::OCC_W'(lrukv_pkg::DEPTH);
    end else if (dec_o.put) begin
      dec_o.evict  = 1'b1;
      dec_o.slot   = victim_idx;
      dec_o.thresh = lrukv_pkg::OCC_W'(lru_rank);
    end
  end

endmodule

>>> design/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative 16-entry key-value store with LRU replacement.
// ----------------------------------------------------------------------------
// A command transfer is captured in an input register, and once the output
// register can take a result, the whole lookup and update is done in one
// pass: all sixteen keys are compared in parallel, the entry that becomes
// most recent is chosen, every recency rank is adjusted, and the result
// lands in an output register. The block sustains one command per cycle
// while results are taken; the single update stage working against the
// entry registers is what sets that figure, since each command sees the
// state left by the one before it. A stalled result only holds the
// pipeline when both registers are full. The capacity register may be
// written only while the store is empty; writes at other times are dropped.
// A capacity of zero acts as one and values above sixteen act as sixteen.
// A get that misses returns -1, a put always returns zero as read value, and
// the evicted key reads zero unless a put displaced the least recent entry.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lrukv_pkg::CAP_W-1:0]   cfg_data_i,
  lrukv_in_if.sink                      item_i,
  lrukv_out_if.source                   result_o
);

  // Input register.
  logic                              item_valid_q;
  lrukv_pkg::cmd_e                   cmd_q;
  logic [lrukv_pkg::KEY_W-1:0]       key_q;
  logic [lrukv_pkg::DATA_W-1:0]      value_q;

  // Entry state. Keys, values and ranks are meaningful only where valid.
  logic [lrukv_pkg::DEPTH-1:0]                              valid_q;
  logic [lrukv_pkg::DEPTH-1:0][lrukv_pkg::KEY_W-1:0]        keys_q;
  logic [lrukv_pkg::DEPTH-1:0][lrukv_pkg::DATA_W-1:0]       values_q;
  logic [lrukv_pkg::DEPTH-1:0][lrukv_pkg::IDX_W-1:0]        ranks_q;
  logic [lrukv_pkg::OCC_W-1:0]                              occ_q;
  logic [lrukv_pkg::CAP_W-1:0]                              cap_q;

  // Result register.
  logic                              res_valid_q;
  logic                              res_hit_q;
  logic [lrukv_pkg::DATA_W-1:0]      res_value_q;
  logic                              res_evicted_q;
  logic [lrukv_pkg::KEY_W-1:0]       res_evkey_q;

  logic                              advance;
  logic                              fire;
  logic [lrukv_pkg::OCC_W-1:0]       eff_cap;
  lrukv_pkg::decision_t              dec;

  // The update stage may run whenever the result register is free or is
  // being emptied in this same cycle.
  assign advance      = !res_valid_q || result_o.ready;
  assign fire         = item_valid_q && advance;
  assign item_i.ready = !item_valid_q || advance;

  // Capacity clamp: zero behaves as one, anything past the depth saturates.
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = lrukv_pkg::OCC_W'(1);
    end else if (32'(cap_q) > lrukv_pkg::DEPTH) begin
      eff_cap = lrukv_pkg::OCC_W'(lrukv_pkg::DEPTH);
    end else begin
      eff_cap = lrukv_pkg::OCC_W'(cap_q);
    end
  end

  lrukv_lookup u_lookup (
    .command_i   (cmd_q),
    .key_i       (key_q),
    .valid_i     (valid_q),
    .keys_i      (keys_q),
    .ranks_i     (ranks_q),
    .occupancy_i (occ_q),
    .eff_cap_i   (eff_cap),
    .dec_o       (dec)
  );

  // Input register: loads on every transfer, empties when its item is used.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (item_i.valid && item_i.ready) begin
      item_valid_q <= 1'b1;
    end else if (fire) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      cmd_q   <= item_i.command;
      key_q   <= item_i.key;
      value_q <= item_i.value;
    end
  end

  // Control state: valid bits, occupancy and capacity.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      cap_q   <= lrukv_pkg::CAP_RESET;
    end else begin
      if (cfg_we_i && (occ_q == '0)) begin
        cap_q <= cfg_data_i;
      end
      if (fire && dec.alloc) begin
        valid_q[dec.slot] <= 1'b1;
        occ_q             <= occ_q + lrukv_pkg::OCC_W'(1);
      end
    end
  end

  // Entry payload and recency. The chosen entry becomes rank zero and every
  // other valid entry that was more recent than its old rank ages by one.
  // A fresh insert uses the full depth as threshold, so every entry ages.
  always_ff @(posedge clk_i) begin
    if (fire && (dec.hit || dec.put)) begin
      for (int i = 0; i < lrukv_pkg::DEPTH; i++) begin
        if (lrukv_pkg::IDX_W'(i) == dec.slot) begin
          ranks_q[i] <= '0;
        end else if (valid_q[i] && (lrukv_pkg::OCC_W'(ranks_q[i]) < dec.thresh)) begin
          ranks_q[i] <= ranks_q[i] + lrukv_pkg::IDX_W'(1);
        end
      end
      if (dec.put) begin
        values_q[dec.slot] <= value_q;
      end
      if (dec.alloc || dec.evict) begin
        keys_q[dec.slot] <= key_q;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (fire) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_hit_q     <= dec.hit;
      res_evicted_q <= dec.evict;
      if (dec.put) begin
        res_value_q <= '0;
      end else if (dec.hit) begin
        res_value_q <= values_q[dec.slot];
      end else begin
        res_value_q <= '1;
      end
      res_evkey_q <= dec.evict ? keys_q[dec.slot] : '0;
    end
  end

  assign result_o.valid       = res_valid_q;
  assign result_o.hit         = res_hit_q;
  assign result_o.read_value  = res_value_q;
  assign result_o.evicted     = res_evicted_q;
  assign result_o.evicted_key = res_evkey_q;

endmodule
